### src/clsc_pkg.sv
// shared types and constants for the color line segment centroid block
`default_nettype none
package clsc_pkg;

   localparam int LINE_PIXELS = 128;
   localparam int POS_W       = $clog2(LINE_PIXELS);
   localparam int COUNT_W     = 8;
   localparam int TOTAL_W     = 13;
   localparam int CENTER_W    = 7;
   localparam int COUNT_MAX   = 255;
   localparam int TOTAL_MAX   = 8191;
   localparam int CENTER_MAX  = 127;
   localparam int DIV_STEPS   = TOTAL_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int REM_W       = COUNT_W;

   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_DETECT_MODE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RED_LIMIT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GREEN_LIMIT = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BLUE_LIMIT  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COUNT_LIMIT = 3'd4;

   localparam logic [1:0] MODE_RED    = 2'd0;
   localparam logic [1:0] MODE_YELLOW = 2'd1;
   localparam logic [1:0] MODE_GREEN  = 2'd2;

   typedef struct packed {
      logic [1:0]         detect_mode;
      logic [4:0]         red_limit;
      logic [2:0]         green_limit;
      logic [4:0]         blue_limit;
      logic [COUNT_W-1:0] count_limit;
   } cfg_type;

   typedef struct packed {
      logic               line_end;
      logic [COUNT_W-1:0] count;
      logic [TOTAL_W-1:0] total;
   } line_sum_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

endpackage
`default_nettype wire

### src/clsc_csr.sv
// configuration register file behind the apb-style port
`default_nettype none
module clsc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [clsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [clsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [clsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output clsc_pkg::cfg_type                    cfg
);
   import clsc_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 write_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_idx)
            REG_DETECT_MODE: cfg_in.detect_mode = csr_pwdata[1:0];
            REG_RED_LIMIT:   cfg_in.red_limit   = csr_pwdata[4:0];
            REG_GREEN_LIMIT: cfg_in.green_limit = csr_pwdata[2:0];
            REG_BLUE_LIMIT:  cfg_in.blue_limit  = csr_pwdata[4:0];
            REG_COUNT_LIMIT: cfg_in.count_limit = csr_pwdata[COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DETECT_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.detect_mode);
         REG_RED_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.red_limit);
         REG_GREEN_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.green_limit);
         REG_BLUE_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.blue_limit);
         REG_COUNT_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.count_limit);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_mode <= MODE_RED;
         cfg_ff.red_limit   <= 5'd8;
         cfg_ff.green_limit <= 3'd1;
         cfg_ff.blue_limit  <= 5'd1;
         cfg_ff.count_limit <= COUNT_W'(40);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### src/clsc_pixel.sv
// pixel classifier, three-tap smoother and per-line count and index accumulator
`default_nettype none
module clsc_pixel (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pixel_take,
   input  wire logic [7:0]        first_byte,
   input  wire logic [7:0]        second_byte,
   input  wire logic              last_pixel,
   input  wire clsc_pkg::cfg_type cfg,
   output clsc_pkg::line_sum_type line_sum
);
   import clsc_pkg::*;

   localparam int CSUM_W = COUNT_W + 2;
   localparam int TSUM_W = TOTAL_W + 2;

   logic               prev_one_ff, prev_one_in;
   logic               prev_two_ff, prev_two_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [4:0]         red;
   logic [2:0]         green;
   logic [4:0]         blue;
   logic               class_bit;
   logic               line_end;
   logic               hit_a;
   logic               hit_b;
   logic [POS_W-1:0]   idx_a;
   logic [CSUM_W-1:0]  count_sum;
   logic [TSUM_W-1:0]  total_sum;
   logic [COUNT_W-1:0] count_next;
   logic [TOTAL_W-1:0] total_next;

   assign red   = first_byte[7:3];
   assign blue  = second_byte[4:0];
   assign green = first_byte[2:0] | second_byte[7:5];

   always_comb begin
      case (cfg.detect_mode)
         MODE_RED:    class_bit = (red > cfg.red_limit) && (green <= cfg.green_limit)
                                  && (blue <= cfg.blue_limit);
         MODE_YELLOW: class_bit = (red > cfg.red_limit) && (green >= cfg.green_limit)
                                  && (blue < cfg.blue_limit);
         MODE_GREEN:  class_bit = (red < cfg.red_limit) && (green >= cfg.green_limit)
                                  && (blue < cfg.blue_limit);
         default:     class_bit = 1'b0;
      endcase
   end

   assign line_end = last_pixel || (pos_ff >= POS_W'(LINE_PIXELS - 1));

   // first pixel of the line is only decided by the end-pixel rule
   always_comb begin
      hit_a = 1'b0;
      idx_a = '0;
      if (pos_ff == POS_W'(1)) begin
         hit_a = prev_one_ff && class_bit;
      end else if (pos_ff >= POS_W'(2)) begin
         hit_a = (prev_two_ff && prev_one_ff) || (prev_two_ff && class_bit)
                 || (prev_one_ff && class_bit);
         idx_a = pos_ff - POS_W'(1);
      end
   end

   assign hit_b = line_end && (pos_ff != '0) && prev_one_ff && class_bit;

   assign count_sum = CSUM_W'(count_ff) + CSUM_W'(hit_a) + CSUM_W'(hit_b);
   assign total_sum = TSUM_W'(total_ff) + (hit_a ? TSUM_W'(idx_a) : '0)
                      + (hit_b ? TSUM_W'(pos_ff) : '0);

   assign count_next = (count_sum > CSUM_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                        : count_sum[COUNT_W-1:0];
   assign total_next = (total_sum > TSUM_W'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                        : total_sum[TOTAL_W-1:0];

   assign line_sum.line_end = line_end;
   assign line_sum.count    = count_next;
   assign line_sum.total    = total_next;

   always_comb begin
      prev_one_in = prev_one_ff;
      prev_two_in = prev_two_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      if (pixel_take) begin
         if (line_end) begin
            prev_one_in = 1'b0;
            prev_two_in = 1'b0;
            pos_in      = '0;
            count_in    = '0;
            total_in    = '0;
         end else begin
            prev_one_in = class_bit;
            prev_two_in = prev_one_ff;
            pos_in      = pos_ff + POS_W'(1);
            count_in    = count_next;
            total_in    = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_one_ff <= 1'b0;
         prev_two_ff <= 1'b0;
         pos_ff      <= '0;
         count_ff    <= '0;
         total_ff    <= '0;
      end else begin
         prev_one_ff <= prev_one_in;
         prev_two_ff <= prev_two_in;
         pos_ff      <= pos_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
      end
   end

endmodule
`default_nettype wire

### src/clsc_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module clsc_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [clsc_pkg::TOTAL_W-1:0]  dividend,
   input  wire logic [clsc_pkg::COUNT_W-1:0]  divisor,
   output logic                               done,
   output logic      [clsc_pkg::TOTAL_W-1:0]  quotient
);
   import clsc_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0] quot_ff, quot_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [REM_W:0]     shifted;
   logic               fits;

   assign shifted  = {rem_ff, quot_ff[TOTAL_W-1]};
   assign fits     = shifted >= {1'b0, div_ff};
   assign done     = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quot_in = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? REM_W'(shifted - {1'b0, div_ff}) : shifted[REM_W-1:0];
         quot_in = {quot_ff[TOTAL_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

endmodule
`default_nettype wire

### src/color_line_segment_centroid.sv
// top level: pixel stream in, one count and centroid transfer out per camera line
// a pixel that does not end the line is taken one per clock while the sequencer is idle;
// a line-end pixel starts the divider; the result is loaded into the output register once
// the divider is done and the output is free, the next pixel is taken after that load
// at the earliest, and req_tready stays low meanwhile and while the previous result waits
// reset: synchronous, clears line state and the sequencer, registers return to defaults
`default_nettype none
module color_line_segment_centroid (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // first_byte [7:0], second_byte [15:8]
   input  wire logic [clsc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // last_pixel
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // hit_count [7:0], over_limit [8], center_index [15:9], center_valid [16], zero [23:17]
   output logic      [clsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [clsc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [clsc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [clsc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import clsc_pkg::*;

   cfg_type            cfg;
   line_sum_type       line_sum;
   state_type          state_ff, state_in;
   logic               pixel_take;
   logic               div_start;
   logic               div_done;
   logic [TOTAL_W-1:0] quotient;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               out_free;
   logic               load_out;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CENTER_W-1:0] center;
   logic               over;
   logic               has_hits;

   clsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   clsc_pixel u_pixel (
      .clock       (clock),
      .reset       (reset),
      .pixel_take  (pixel_take),
      .first_byte  (req_tdata[7:0]),
      .second_byte (req_tdata[15:8]),
      .last_pixel  (req_tlast),
      .cfg         (cfg),
      .line_sum    (line_sum)
   );

   clsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (line_sum.total),
      .divisor  (line_sum.count),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign pixel_take = req_tvalid && req_tready;
   assign div_start  = pixel_take && line_sum.line_end;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign has_hits = (count_ff != '0);
   assign over     = count_ff > cfg.count_limit;
   assign center   = !has_hits ? '0
                   : (quotient > TOTAL_W'(CENTER_MAX)) ? CENTER_W'(CENTER_MAX)
                   : quotient[CENTER_W-1:0];

   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               count_in = line_sum.count;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RSP_DATA_W - COUNT_W - CENTER_W - 2)'(0), has_hits, center, over,
                         count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16] == (rsp_tdata[7:0] != '0)))
      else $error("center_valid disagrees with hit_count");

   a_empty_center: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[16]) |-> (rsp_tdata[15:9] == '0))
      else $error("empty line gives a nonzero center");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !req_tready)
      else $error("input taken while the divider runs");

endmodule
`default_nettype wire

### sim/color_line_segment_centroid_test.sv
// self-checking testbench for color_line_segment_centroid: pixel lines in, checked centroids out
module color_line_segment_centroid_test;
   timeunit 1ns;
   timeprecision 1ps;

   import clsc_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 500;
   localparam int PHASE_PIXELS  = 100;

   typedef struct {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       last_pixel;
   } pixel_type;

   typedef struct {
      logic [7:0] hit_count;
      logic       over_limit;
      logic [6:0] center_index;
      logic       center_valid;
   } line_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   color_line_segment_centroid i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pixel_type       pixel_queue[$];
   line_result_type results_due[$];
   int           error_count = 0;
   int           stall_cycles = 0;
   logic         req_done = 1'b0;
   int unsigned  send_gap_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int           hold_request = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   // line state of the predictor
   cfg_type      line_cfg = '{detect_mode: MODE_RED, red_limit: 5'd8, green_limit: 3'd1,
                              blue_limit: 5'd1, count_limit: 8'd40};
   logic         class_one = 1'b0;
   logic         class_two = 1'b0;
   int unsigned  pixel_position = 0;
   int unsigned  set_count = 0;
   int unsigned  index_total = 0;

   task automatic add_hit(logic hit, int unsigned index);
      if (hit) begin
         if (set_count < COUNT_MAX)
            set_count++;
         index_total = index_total + index;
         if (index_total > TOTAL_MAX)
            index_total = TOTAL_MAX;
      end
   endtask

   task automatic track_pixel(logic [7:0] first_byte, logic [7:0] second_byte, logic last_pixel);
      int unsigned  red;
      int unsigned  green;
      int unsigned  blue;
      int unsigned  pos;
      int unsigned  center;
      logic         hit;
      logic         line_end;
      line_result_type res;
      red   = first_byte[7:3];
      blue  = second_byte[4:0];
      green = first_byte[2:0] | second_byte[7:5];
      case (line_cfg.detect_mode)
         MODE_RED: begin
            hit = red > line_cfg.red_limit && green <= line_cfg.green_limit
                  && blue <= line_cfg.blue_limit;
         end
         MODE_YELLOW: begin
            hit = red > line_cfg.red_limit && green >= line_cfg.green_limit
                  && blue < line_cfg.blue_limit;
         end
         MODE_GREEN: begin
            hit = red < line_cfg.red_limit && green >= line_cfg.green_limit
                  && blue < line_cfg.blue_limit;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      pos = pixel_position;
      line_end = last_pixel || pos >= LINE_PIXELS - 1;
      if (pos == 1)
         add_hit(class_one & hit, 0);
      else if (pos >= 2)
         add_hit((int'(class_two) + int'(class_one) + int'(hit)) >= 2, pos - 1);
      if (line_end && pos >= 1)
         add_hit(class_one & hit, pos);
      class_two = class_one;
      class_one = hit;
      if (!line_end) begin
         pixel_position = pos + 1;
      end else begin
         center = 0;
         if (set_count != 0) begin
            center = index_total / set_count;
            if (center > CENTER_MAX)
               center = CENTER_MAX;
         end
         res.hit_count    = set_count[7:0];
         res.over_limit   = set_count > line_cfg.count_limit;
         res.center_index = center[6:0];
         res.center_valid = set_count != 0;
         results_due.push_back(res);
         class_one      = 1'b0;
         class_two      = 1'b0;
         pixel_position = 0;
         set_count      = 0;
         index_total    = 0;
      end
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // pixel driver
   always @(negedge clock) begin
      pixel_type px;
      if (!reset && (!req_tvalid || req_done)) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            px = pixel_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {px.second_byte, px.first_byte};
            req_tlast  <= px.last_pixel;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_request) begin
         hold_seen  <= hold_request;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         req_done <= 1'b0;
      end else begin
         req_done <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("result transfer with no line end pending: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("hit_count", want.hit_count, rsp_tdata[7:0]);
               compare_field("over_limit", want.over_limit, rsp_tdata[8]);
               compare_field("center_index", want.center_index, rsp_tdata[15:9]);
               compare_field("center_valid", want.center_valid, rsp_tdata[16]);
               compare_field("zero pad", 0, rsp_tdata[23:17]);
            end
         end
         if (req_tvalid && req_tready)
            track_pixel(req_tdata[7:0], req_tdata[15:8], req_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("color_line_segment_centroid_test: done, errors");
            $finish;
         end
      end
   end

   task automatic write_register(logic [REG_IDX_W-1:0] index, logic [31:0] value);
      logic [31:0] kept;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      kept = '0;
      case (index)
         REG_DETECT_MODE: begin
            line_cfg.detect_mode = value[1:0];
            kept[1:0] = value[1:0];
         end
         REG_RED_LIMIT: begin
            line_cfg.red_limit = value[4:0];
            kept[4:0] = value[4:0];
         end
         REG_GREEN_LIMIT: begin
            line_cfg.green_limit = value[2:0];
            kept[2:0] = value[2:0];
         end
         REG_BLUE_LIMIT: begin
            line_cfg.blue_limit = value[4:0];
            kept[4:0] = value[4:0];
         end
         REG_COUNT_LIMIT: begin
            line_cfg.count_limit = value[7:0];
            kept[7:0] = value[7:0];
         end
         default: begin
         end
      endcase
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      compare_field("register readback", kept, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic int unsigned pick_in(int lo, int hi, int unsigned top);
      if (lo > hi)
         return $urandom_range(top, 0);
      return $urandom_range(hi, lo);
   endfunction

   // a pixel that passes the current color test, or random bytes
   function automatic pixel_type make_pixel(bit want_hit);
      pixel_type   px;
      int unsigned red;
      int unsigned green;
      int unsigned blue;
      logic [2:0]  green_lo;
      logic [2:0]  green_hi;
      int          rl;
      int          gl;
      int          bl;
      rl = line_cfg.red_limit;
      gl = line_cfg.green_limit;
      bl = line_cfg.blue_limit;
      px.last_pixel = 1'b0;
      if (!want_hit || line_cfg.detect_mode == MODE_UNUSED) begin
         px.first_byte  = $urandom_range(255, 0);
         px.second_byte = $urandom_range(255, 0);
         return px;
      end
      case (line_cfg.detect_mode)
         MODE_RED: begin
            red   = pick_in(rl + 1, 31, 31);
            green = pick_in(0, gl, 7);
            blue  = pick_in(0, bl, 31);
         end
         MODE_YELLOW: begin
            red   = pick_in(rl + 1, 31, 31);
            green = pick_in(gl, 7, 7);
            blue  = pick_in(0, bl - 1, 31);
         end
         default: begin
            red   = pick_in(0, rl - 1, 31);
            green = pick_in(gl, 7, 7);
            blue  = pick_in(0, bl - 1, 31);
         end
      endcase
      green_lo = green[2:0] & 3'($urandom_range(7, 0));
      green_hi = (green[2:0] & ~green_lo) | (green_lo & 3'($urandom_range(7, 0)));
      px.first_byte  = {red[4:0], green_lo};
      px.second_byte = {green_hi, blue[4:0]};
      return px;
   endfunction

   // a line of pixels with runs of hits and some noise
   task automatic queue_line(int len, bit mark_end);
      pixel_type px;
      bit        in_run;
      in_run = $urandom_range(1, 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(5, 0) == 0)
            in_run = !in_run;
         px = make_pixel(in_run ? ($urandom_range(9, 0) != 0) : ($urandom_range(9, 0) == 0));
         px.last_pixel = (i == len - 1) ? mark_end : 1'b0;
         pixel_queue.push_back(px);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_tvalid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          phase_pixels;
      int          len;
      int          sel;
      bit          paused;
      logic [1:0]  mode;
      logic [31:0] red_lim;
      logic [31:0] green_lim;
      logic [31:0] blue_lim;
      logic [31:0] count_lim;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed lines at the reset thresholds
      pixel_queue.push_back('{8'hFF, 8'hFF, 1'b1});
      pixel_queue.push_back('{8'h00, 8'h00, 1'b1});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b1});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h48, 8'h21, 1'b1});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h40, 8'h00, 1'b1});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h48, 8'h21, 1'b0});
      pixel_queue.push_back('{8'h07, 8'hE0, 1'b0});
      pixel_queue.push_back('{8'hF8, 8'h01, 1'b0});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h48, 8'h00, 1'b1});
      pixel_queue.push_back('{8'h00, 8'hFF, 1'b0});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h49, 8'h22, 1'b0});
      pixel_queue.push_back('{8'hF8, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h00, 8'h00, 1'b1});
      pixel_queue.push_back('{8'hFF, 8'h00, 1'b0});
      pixel_queue.push_back('{8'h07, 8'hE0, 1'b1});
      wait_drained();

      for (int k = 0; k < 8; k++) begin
         case (k / 2)
            0: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_gap_pct = 76;
               recv_stall_pct = 0;
            end
            2: begin
               send_gap_pct = 0;
               recv_stall_pct = 76;
            end
            default: begin
               send_gap_pct = 11;
               recv_stall_pct = 11;
            end
         endcase
         mode = 2'(k % 4);
         if (k == 1) begin
            red_lim = 0;
            green_lim = 0;
            blue_lim = 0;
            count_lim = 0;
         end else if (k == 4 || k == 6) begin
            red_lim = 31;
            green_lim = 7;
            blue_lim = 31;
            count_lim = (k == 4) ? 128 : 255;
         end else begin
            red_lim = $urandom_range(31, 0);
            green_lim = $urandom_range(7, 0);
            blue_lim = $urandom_range(31, 0);
            count_lim = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 0);
         end
         write_register(REG_DETECT_MODE, mode);
         write_register(REG_RED_LIMIT, red_lim);
         write_register(REG_GREEN_LIMIT, green_lim);
         write_register(REG_BLUE_LIMIT, blue_lim);
         write_register(REG_COUNT_LIMIT, count_lim);

         phase_pixels = 0;
         paused = 0;
         while (phase_pixels < PHASE_PIXELS) begin
            sel = $urandom_range(19, 0);
            if (sel < 2)
               len = $urandom_range(3, 1);
            else if (sel < 16)
               len = $urandom_range(32, 4);
            else if (sel < 19)
               len = $urandom_range(LINE_PIXELS - 1, 33);
            else
               len = LINE_PIXELS;
            // a full-length line may leave its end mark out
            queue_line(len, (len < LINE_PIXELS) ? 1'b1 : 1'($urandom_range(1, 0)));
            phase_pixels += len;
            if (k == 0 && !paused && phase_pixels >= PHASE_PIXELS / 2) begin
               wait_drained();
               paused = 1;
            end
         end
         // receiver holds off while the sender keeps offering
         if (k == 1)
            hold_request++;
         wait_drained();
      end

      if (error_count == 0)
         $display("color_line_segment_centroid_test: done, clean");
      else
         $display("color_line_segment_centroid_test: done, errors");
      $finish;
   end

endmodule
